// ===== rtl/fit_policy_block_placer_defines.svh =====
// Assertion macros used by the placer datapath.
`ifndef FIT_POLICY_BLOCK_PLACER_DEFINES_SVH
`define FIT_POLICY_BLOCK_PLACER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define FPBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define FPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fpbp_pkg.sv =====
// Types, codes and constants shared by the placer modules.
package fpbp_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int IDX_W      = 4;
	localparam int AMT_W      = 16;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PLACE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_LOADED = 2'd0,
		STAT_PLACED = 2'd1,
		STAT_NOFIT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY_MODE = 2'd0,
		REG_BLOCK_COUNT = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] load_index;
		logic [AMT_W-1:0] amount;
	} req_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] chosen_block;
		logic [AMT_W-1:0] remaining;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_WAIT = 2'd2,
		ST_DONE = 2'd3
	} fsm_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_place;
		logic no_blocks;
		logic last_issue;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/fpbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fpbp_ctrl.sv =====
// Sequencing state machine: accept, table scan, final compare, commit.
module fpbp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fpbp_pkg::dp_stat_t stat,
	output fpbp_pkg::dp_cmd_t  cmd
);

	fpbp_pkg::fsm_state_t state_q;
	fpbp_pkg::fsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpbp_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (stat.is_place && !stat.no_blocks) begin
						state_nxt = fpbp_pkg::ST_SCAN;
					end else begin
						state_nxt = fpbp_pkg::ST_DONE;
					end
				end
			end
			fpbp_pkg::ST_SCAN: begin
				if (stat.last_issue) begin
					state_nxt = fpbp_pkg::ST_WAIT;
				end
			end
			fpbp_pkg::ST_WAIT: begin
				state_nxt = fpbp_pkg::ST_DONE;
			end
			fpbp_pkg::ST_DONE: begin
				if (stat.out_free) begin
					state_nxt = fpbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = fpbp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall  = (state_q != fpbp_pkg::ST_IDLE);
		cmd.accept = (state_q == fpbp_pkg::ST_IDLE) && req_valid;
		cmd.issue  = (state_q == fpbp_pkg::ST_SCAN);
		cmd.commit = (state_q == fpbp_pkg::ST_DONE) && stat.out_free;
	end

endmodule

// ===== rtl/fpbp_dpath.sv =====
// Datapath: size table, scan compare, pointer, settings and result register.
`include "fit_policy_block_placer_defines.svh"

module fpbp_dpath #(
	parameter int MAX_BLOCKS = fpbp_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpbp_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fpbp_pkg::dp_cmd_t                  cmd,
	output fpbp_pkg::dp_stat_t                 stat,
	input  fpbp_pkg::req_word_t                req_word,
	input  logic                               cfg_we,
	input  logic [fpbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output fpbp_pkg::rsp_word_t                rsp_word
);

	localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int NW  = (CW > fpbp_pkg::COUNT_W) ? CW : fpbp_pkg::COUNT_W;
	localparam int XW  = (IW > fpbp_pkg::IDX_W) ? IW : fpbp_pkg::IDX_W;
	localparam int LW  = (CW > fpbp_pkg::IDX_W) ? CW : fpbp_pkg::IDX_W;
	localparam int AXW = (SIZE_BITS > fpbp_pkg::AMT_W) ? SIZE_BITS : fpbp_pkg::AMT_W;

	// settings
	fpbp_pkg::policy_t               policy_q;
	logic [fpbp_pkg::COUNT_W-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= fpbp_pkg::FIT_FIRST;
			count_q  <= fpbp_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpbp_pkg::REG_POLICY_MODE: policy_q <= fpbp_pkg::policy_t'(cfg_data[1:0]);
				fpbp_pkg::REG_BLOCK_COUNT: count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp block count to the table depth
	logic [NW-1:0] count_ext;
	logic [NW-1:0] n_ext;
	logic [CW-1:0] n_blocks;

	assign count_ext = NW'(count_q);
	assign n_ext     = (count_ext > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : count_ext;
	assign n_blocks  = n_ext[CW-1:0];

	// held item
	logic                        cmd_q;
	logic [fpbp_pkg::IDX_W-1:0]  lidx_q;
	logic [SIZE_BITS-1:0]        req_q;
	logic [AXW-1:0]              amt_ext;

	assign amt_ext = AXW'(req_word.amount);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= req_word.cmd;
			lidx_q <= req_word.load_index;
			req_q  <= amt_ext[SIZE_BITS-1:0];
		end
	end

	// scan address and count
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] scan_start;
	logic [CW-1:0] pos_plus;
	logic [IW-1:0] pos_next;

	assign scan_start = ((policy_q == fpbp_pkg::FIT_NEXT) && (CW'(ptr_q) < n_blocks)) ?
		ptr_q : '0;
	assign pos_plus   = CW'(pos_q) + CW'(1);
	assign pos_next   = (pos_plus == n_blocks) ? '0 : pos_plus[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= scan_start;
			cnt_q <= '0;
		end else if (cmd.issue) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// table with per-entry valid bits; an unwritten entry reads as zero
	logic [MAX_BLOCKS-1:0] vld_q;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [SIZE_BITS-1:0]  ram_wdata;
	logic [SIZE_BITS-1:0]  ram_rdata;

	fpbp_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.issue),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	// compare stage, one entry a cycle
	logic                 cmp_v_s1;
	logic                 vld_s1;
	logic [IW-1:0]        pos_s1;
	logic [SIZE_BITS-1:0] cand_size;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 pick_v_q;
	logic [IW-1:0]        pick_idx_q;
	logic [SIZE_BITS-1:0] pick_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			vld_s1 <= vld_q[pos_q];
			pos_s1 <= pos_q;
		end
	end

	assign cand_size = vld_s1 ? ram_rdata : '0;
	assign fits      = (cand_size >= req_q);

	always_comb begin
		unique case (policy_q)
			fpbp_pkg::FIT_BEST:  better = (cand_size < pick_size_q);
			fpbp_pkg::FIT_WORST: better = (cand_size > pick_size_q);
			default:             better = 1'b0;
		endcase
	end

	assign take = cmp_v_s1 && fits && (!pick_v_q || better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_v_q <= 1'b0;
		end else if (cmd.accept) begin
			pick_v_q <= 1'b0;
		end else if (take) begin
			pick_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pick_idx_q  <= pos_s1;
			pick_size_q <= cand_size;
		end
	end

	// commit
	logic                 is_load;
	logic                 in_table;
	logic [XW-1:0]        lidx_ext;
	logic [XW-1:0]        pick_ext;
	logic [SIZE_BITS-1:0] new_size;
	logic [AXW-1:0]       req_ext;
	logic [AXW-1:0]       size_ext;
	logic [CW-1:0]        pick_plus;
	logic [IW-1:0]        ptr_after;
	fpbp_pkg::rsp_word_t  rsp_nxt;

	assign is_load   = (cmd_q == fpbp_pkg::CMD_LOAD);
	assign in_table  = (LW'(lidx_q) < LW'(MAX_BLOCKS));
	assign lidx_ext  = XW'(lidx_q);
	assign pick_ext  = XW'(pick_idx_q);
	assign new_size  = pick_size_q - req_q;
	assign req_ext   = AXW'(req_q);
	assign size_ext  = AXW'(new_size);
	assign pick_plus = CW'(pick_idx_q) + CW'(1);
	assign ptr_after = (pick_plus == n_blocks) ? '0 : pick_plus[IW-1:0];

	assign ram_we    = cmd.commit && (is_load ? in_table : pick_v_q);
	assign ram_waddr = is_load ? lidx_ext[IW-1:0] : pick_idx_q;
	assign ram_wdata = is_load ? req_q : new_size;

	always_comb begin
		if (is_load) begin
			rsp_nxt.status       = fpbp_pkg::STAT_LOADED;
			rsp_nxt.chosen_block = lidx_q;
			rsp_nxt.remaining    = in_table ? req_ext[fpbp_pkg::AMT_W-1:0] : '0;
		end else if (pick_v_q) begin
			rsp_nxt.status       = fpbp_pkg::STAT_PLACED;
			rsp_nxt.chosen_block = pick_ext[fpbp_pkg::IDX_W-1:0];
			rsp_nxt.remaining    = size_ext[fpbp_pkg::AMT_W-1:0];
		end else begin
			rsp_nxt.status       = fpbp_pkg::STAT_NOFIT;
			rsp_nxt.chosen_block = '0;
			rsp_nxt.remaining    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.commit) begin
			if (is_load) begin
				ptr_q <= '0;
			end else if (pick_v_q && (policy_q == fpbp_pkg::FIT_NEXT)) begin
				ptr_q <= ptr_after;
			end
		end
	end

	// result register
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_word <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;

	assign stat.is_place   = (req_word.cmd == fpbp_pkg::CMD_PLACE);
	assign stat.no_blocks  = (n_blocks == '0);
	assign stat.last_issue = ((cnt_q + CW'(1)) == n_blocks);
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	`FPBP_ASSERT_NOW(a_pick_fits, cmd.commit && !is_load && pick_v_q, pick_size_q >= req_q, "chosen block smaller than request")
	`FPBP_ASSERT_NEXT(a_pick_cleared, cmd.accept, !pick_v_q, "new item started with a stale candidate")
	`FPBP_ASSERT_NEXT(a_no_repeat, rsp_valid_q && !rsp_stall && !cmd.commit, !rsp_valid_q, "result word shown again after it was taken")

endmodule

// ===== rtl/fit_policy_block_placer.sv =====
// Top level of the fit-policy block placer.
// Keeps one free size per table block and places requests under first, best,
// worst or next fit, chosen by the policy_mode register (index 0); block_count
// (index 1) sets how many blocks from index zero are in use, clamped to
// MAX_BLOCKS. A load word writes one block's size and sends the next-fit
// pointer back to block 0; a place word scans the blocks in use and takes its
// size from the chosen one. Each request word yields exactly one result word.
// Sequence: a load goes from the accept step straight to the write-back; a
// place scans the clamped block count of entries, then does the last compare
// and the write-back; with no block in use the scan is skipped. The scan reads
// one table entry per cycle through the single read port of the table RAM and
// one comparator, after the accept cycle. The write-back waits while the
// previous result word is still stalled in the output register. The next
// request word is taken as soon as the previous result sits in the output
// register, even if that word is still stalled downstream. The table comes
// out of reset empty (all sizes zero) at once, through per-block valid bits:
// there is no clearing pass. Configuration writes are always ready and must
// only be issued while idle.
module fit_policy_block_placer #(
	parameter int MAX_BLOCKS = fpbp_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpbp_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  fpbp_pkg::req_word_t             req_word,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output fpbp_pkg::rsp_word_t             rsp_word,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpbp_pkg::CFG_DATA_W-1:0] cfg_data
);

	fpbp_pkg::dp_cmd_t  dp_cmd;
	fpbp_pkg::dp_stat_t dp_stat;
	logic               cfg_we;

	// Register writes never wait; unknown indexes drop in the datapath.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequence each word: accept, then for a place the scan and last compare, then commit.
	fpbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Hold the table, the pointer, the settings and the result word.
	fpbp_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.req_word  (req_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule
